// File: design/cpd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the packet deframer.
// No dependencies; the deframer core imports this package.
package cpd_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int HDR_LEN = 6;
  localparam int HDR_IDX_W = 3;
  localparam int LEN_POS = 5;
  localparam int INDEX_W = 5;

  localparam logic [7:0] START_BYTE_RST = 8'h7E;
  localparam logic [7:0] CRC_POLY = 8'h1D;
  localparam logic [7:0] CRC_INIT = 8'h00;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_START = 3'd1,
    STATUS_TOO_LONG  = 3'd2,
    STATUS_CRC_ERR   = 3'd3,
    STATUS_TRUNCATED = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         payload_value;
    logic [INDEX_W-1:0] payload_index;
    logic [7:0]         source_id;
    logic [7:0]         dest_id;
    logic [7:0]         frame_type;
    logic [7:0]         message_id;
    logic [7:0]         hop_limit;
    logic [7:0]         payload_length;
    status_t            status;
    logic               run_last;
  } res_t;

  // MSB-first CRC-8 update of one byte; eight shift/XOR steps on 8 bits.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/cpd_if.sv
// Valid/ready channel interfaces for received bytes and for result items.
// Depends on nothing but the signals they carry.
interface cpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface cpd_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_value;
  logic [4:0] payload_index;
  logic [7:0] source_id;
  logic [7:0] dest_id;
  logic [7:0] frame_type;
  logic [7:0] message_id;
  logic [7:0] hop_limit;
  logic [7:0] payload_length;
  logic [2:0] status;
  logic       run_last;

  modport source (
    output valid, output kind, output payload_value, output payload_index,
    output source_id, output dest_id, output frame_type, output message_id,
    output hop_limit, output payload_length, output status, output run_last,
    input ready
  );
  modport sink (
    input valid, input kind, input payload_value, input payload_index,
    input source_id, input dest_id, input frame_type, input message_id,
    input hop_limit, input payload_length, input status, input run_last,
    output ready
  );
endinterface

// File: design/crc8_packet_deframer_core.sv
// Framed packet receiver with CRC-8 check: the top level of the block.
// Depends on cpd_pkg and the channel interfaces in cpd_if.sv.
//
// The block takes one received byte per cycle while rx.ready is high and parses start
// byte, six header bytes, the payload and a trailing CRC-8 (polynomial 0x1D, initial
// value 0, no reflection, start byte excluded). Each byte is decoded by a single pass
// of logic in the cycle of its transfer; its zero, one or two results are written into
// a four-entry output queue and can be taken from the cycle after. Input is ready while
// the queue has at least two free entries, so bytes that cause at most one result stream
// at one per cycle while results are taken; a payload byte that also ends the buffer
// yields two results. The start byte is set through cfg_we/cfg_wdata and resets to 0x7E.
module crc8_packet_deframer_core #(
  parameter int MAX_PAYLOAD = cpd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  cpd_rx_if.sink          rx,
  cpd_res_if.source       result
);
  import cpd_pkg::*;

  localparam int LEN_BITS = $clog2(MAX_PAYLOAD + 1);
  localparam int CNT_W = (LEN_BITS > INDEX_W) ? LEN_BITS : INDEX_W;
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);
  localparam logic [CNT_W-1:0] LAST_HDR = CNT_W'(HDR_LEN - 1);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    PH_AWAIT   = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CRC     = 4'b1000
  } phase_t;

  logic [7:0]       start_byte;
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       hdr [HDR_LEN];
  logic [7:0]       hdr_next [HDR_LEN];
  logic [7:0]       crc, crc_next;
  logic             frame_done, frame_done_next;

  res_t             queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   q_count;

  logic       accept, pop;
  logic       pay_en, sum_en;
  status_t    sum_status;
  logic [7:0] b;
  logic       last;
  res_t       slot0, slot1, pay_res, sum_res;
  logic [1:0] push_n;

  assign b      = rx.rx_byte;
  assign last   = rx.buffer_end;
  assign rx.ready = (q_count <= (QPTR_W + 1)'(QDEPTH - 2));
  assign accept = rx.valid && rx.ready;
  assign pop    = result.valid && result.ready;

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    crc_next        = crc;
    frame_done_next = frame_done;
    for (int i = 0; i < HDR_LEN; i++) begin
      hdr_next[i] = hdr[i];
    end
    pay_en     = 1'b0;
    sum_en     = 1'b0;
    sum_status = STATUS_OK;

    if (frame_done) begin
      // Skipping the rest of a buffer whose frame is already reported.
      if (last) begin
        frame_done_next = 1'b0;
        phase_next      = PH_AWAIT;
      end
    end else begin
      case (phase)
        PH_HEADER: begin
          hdr_next[byte_count[HDR_IDX_W-1:0]] = b;
          crc_next        = crc8_feed(crc, b);
          byte_count_next = byte_count + 1'b1;
          if (byte_count == LAST_HDR) begin
            if (b > MAX_LEN) begin
              sum_en     = 1'b1;
              sum_status = STATUS_TOO_LONG;
            end else if (last) begin
              sum_en     = 1'b1;
              sum_status = STATUS_TRUNCATED;
            end else begin
              byte_count_next = '0;
              phase_next      = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end else if (last) begin
            sum_en     = 1'b1;
            sum_status = STATUS_TRUNCATED;
          end
        end
        PH_PAYLOAD: begin
          pay_en          = 1'b1;
          crc_next        = crc8_feed(crc, b);
          byte_count_next = byte_count + 1'b1;
          if (last) begin
            sum_en     = 1'b1;
            sum_status = STATUS_TRUNCATED;
          end else if (8'(byte_count_next) >= hdr[LEN_POS]) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          sum_en     = 1'b1;
          sum_status = (b == crc) ? STATUS_OK : STATUS_CRC_ERR;
        end
        default: begin
          for (int i = 0; i < HDR_LEN; i++) begin
            hdr_next[i] = 8'd0;
          end
          crc_next        = CRC_INIT;
          byte_count_next = '0;
          if (b != start_byte) begin
            sum_en     = 1'b1;
            sum_status = STATUS_BAD_START;
          end else if (last) begin
            sum_en     = 1'b1;
            sum_status = STATUS_TRUNCATED;
          end else begin
            phase_next = PH_HEADER;
          end
        end
      endcase
      if (sum_en) begin
        phase_next      = PH_AWAIT;
        frame_done_next = !last;
      end
    end
  end

  // Result items carry the header as it stands after this byte.
  always_comb begin
    pay_res.kind           = KIND_PAYLOAD;
    pay_res.payload_value  = b;
    pay_res.payload_index  = byte_count[INDEX_W-1:0];
    pay_res.source_id      = hdr_next[0];
    pay_res.dest_id        = hdr_next[1];
    pay_res.frame_type     = hdr_next[2];
    pay_res.message_id     = hdr_next[3];
    pay_res.hop_limit      = hdr_next[4];
    pay_res.payload_length = hdr_next[5];
    pay_res.status         = STATUS_OK;
    pay_res.run_last       = !sum_en;

    sum_res                = pay_res;
    sum_res.kind           = KIND_SUMMARY;
    sum_res.payload_value  = 8'd0;
    sum_res.payload_index  = '0;
    sum_res.status         = sum_status;
    sum_res.run_last       = 1'b1;

    slot0  = pay_en ? pay_res : sum_res;
    slot1  = sum_res;
    push_n = {1'b0, pay_en} + {1'b0, sum_en};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
      phase      <= PH_AWAIT;
      byte_count <= '0;
      crc        <= CRC_INIT;
      frame_done <= 1'b0;
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        start_byte <= cfg_wdata;
      end
      if (accept) begin
        phase      <= phase_next;
        byte_count <= byte_count_next;
        crc        <= crc_next;
        frame_done <= frame_done_next;
        for (int i = 0; i < HDR_LEN; i++) begin
          hdr[i] <= hdr_next[i];
        end
      end
    end
  end

  // Output queue: up to two entries written per transfer, one read per cycle while result.ready is high.
  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) begin
      queue[wr_ptr] <= slot0;
    end
    if (accept && push_n == 2'd2) begin
      queue[wr_ptr + 1'b1] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + QPTR_W'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_count <= q_count + (accept ? (QPTR_W + 1)'(push_n) : '0) - (QPTR_W + 1)'(pop);
    end
  end

  res_t head;
  assign head = queue[rd_ptr];

  assign result.valid          = (q_count != '0);
  assign result.kind           = head.kind;
  assign result.payload_value  = head.payload_value;
  assign result.payload_index  = head.payload_index;
  assign result.source_id      = head.source_id;
  assign result.dest_id        = head.dest_id;
  assign result.frame_type     = head.frame_type;
  assign result.message_id     = head.message_id;
  assign result.hop_limit      = head.hop_limit;
  assign result.payload_length = head.payload_length;
  assign result.status         = head.status;
  assign result.run_last       = head.run_last;

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (QPTR_W + 1)'(QDEPTH))
    else $error("output queue holds more entries than it has");

  a_room_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> q_count <= (QPTR_W + 1)'(QDEPTH - 2))
    else $error("byte transfer without room for two results");

  a_skip_in_await: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> phase == PH_AWAIT)
    else $error("skipping bytes while a frame is still open");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> 8'(byte_count) < hdr[LEN_POS])
    else $error("payload count reached the length while still in payload");
`endif

endmodule
